// ===== src/lcmf_pkg.sv =====
package lcmf_pkg;

  // Window length default
  localparam int WINDOW_LEN_DEF = 5;

  // Field widths
  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 32;
  localparam int WEIGHT_W = 48;
  localparam int HELD_W   = 3;

  // Shared multiplier: A operand (gain or EMA difference), B operand (delta or alpha)
  localparam int MUL_AW = WEIGHT_W + 1;
  localparam int MUL_BW = SAMPLE_W + 1;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // EMA weight in Q16, and smallest gain magnitude that counts
  localparam logic [MUL_BW-1:0] SMOOTH_Q16   = MUL_BW'(11796);
  localparam int                GAIN_MIN_MAG = 17;

  // Configuration register indexes
  localparam logic REG_TARE = 1'b0;
  localparam logic REG_GAIN = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] raw_sample;
    logic                       read_ok;
  } lcmf_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] median_count;
    logic signed [WEIGHT_W-1:0] filtered_weight;
    logic                       sensor_ok;
    logic [HELD_W-1:0]          samples_held;
  } lcmf_out_t;

  // Clamp to the 48-bit signed range
  function automatic logic signed [WEIGHT_W-1:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_7FFF_FFFF_FFFF;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      sat48 = hi[WEIGHT_W-1:0];
    end else if (v < lo) begin
      sat48 = lo[WEIGHT_W-1:0];
    end else begin
      sat48 = v[WEIGHT_W-1:0];
    end
  endfunction

endpackage

// ===== src/load_cell_median_ema_filter_top.sv =====
// A good read gives its result after the candidate walk of the median search and two
// passes of the shared bit-serial Booth multiplier; the seeding read skips the second
// pass, and a failed read goes straight to the done state.
// Throughput: one request at a time; the next is taken the cycle after the result is loaded.
// Reset (rst, synchronous, high): window empty, EMA unseeded, tare 0, gain 1.0.
module load_cell_median_ema_filter_top
  import lcmf_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_ready,
  input  lcmf_in_t    sample,
  output logic        result_valid,
  input  logic        result_ready,
  output lcmf_out_t   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(WINDOW_LEN + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MEDIAN = 5'b00010,
    ST_GRAMS  = 5'b00100,
    ST_EMA    = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t state;

  logic signed [SAMPLE_W-1:0] tare_offset;
  logic signed [GAIN_W-1:0]   scale_gain;
  logic signed [SAMPLE_W-1:0] held_median;
  logic signed [WEIGHT_W-1:0] ema_value;
  logic                       ema_seeded;
  logic                       item_ok;

  logic                       med_start;
  logic                       med_done;
  logic signed [SAMPLE_W-1:0] med_value;
  logic [CW-1:0]              fill;

  logic                       mul_start;
  logic                       mul_done;
  logic signed [MUL_AW-1:0]   mul_a;
  logic signed [MUL_BW-1:0]   mul_b;
  logic signed [MUL_PW-1:0]   prod;

  logic                       accept;
  logic                       res_load;
  logic                       tiny_gain;
  logic signed [57:0]         g_round;
  logic signed [WEIGHT_W-1:0] grams;
  logic signed [64:0]         e_round;
  logic signed [49:0]         e_sum;

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tare_offset <= '0;
      scale_gain  <= 32'sd16777216;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_TARE: tare_offset <= pwdata[SAMPLE_W-1:0];
        REG_GAIN: scale_gain  <= pwdata;
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TARE: prdata = 32'(tare_offset);
      REG_GAIN: prdata = scale_gain;
      default:  prdata = '0;
    endcase
  end

  assign sample_ready = (state == ST_IDLE);
  assign accept       = sample_valid && sample_ready;
  assign med_start    = accept && sample.read_ok;
  assign res_load     = (state == ST_DONE) && (!result_valid || result_ready);

  lcmf_median #(.WINDOW_LEN(WINDOW_LEN)) u_median (
    .clk    (clk),
    .rst    (rst),
    .start  (med_start),
    .sample (sample.raw_sample),
    .done   (med_done),
    .median (med_value),
    .fill   (fill)
  );

  // Multiplier operands: gain times (median - tare), then (grams - ema) times alpha
  always_comb begin
    if (state == ST_MEDIAN) begin
      mul_a = MUL_AW'(scale_gain);
      mul_b = MUL_BW'(med_value) - MUL_BW'(tare_offset);
    end else begin
      mul_a = MUL_AW'(grams) - MUL_AW'(ema_value);
      mul_b = SMOOTH_Q16;
    end
  end

  assign mul_start = ((state == ST_MEDIAN) && med_done) ||
                     ((state == ST_GRAMS) && mul_done && ema_seeded);

  lcmf_booth_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (prod)
  );

  // Q24 product to Q16 grams, rounded half up and saturated; a tiny gain gives zero
  assign tiny_gain = (scale_gain < GAIN_W'(GAIN_MIN_MAG)) &&
                     (scale_gain > -GAIN_W'(GAIN_MIN_MAG));
  assign g_round   = prod[57:0] + 58'sd128;
  assign grams     = tiny_gain ? '0 : sat48(64'($signed(g_round[57:8])));

  // EMA step, rounded half up
  assign e_round = prod[64:0] + 65'sd32768;
  assign e_sum   = 50'(ema_value) + 50'($signed(e_round[64:16]));

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      held_median  <= '0;
      ema_value    <= '0;
      ema_seeded   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= sample.read_ok ? ST_MEDIAN : ST_DONE;
          end
        end
        ST_MEDIAN: begin
          if (med_done) begin
            held_median <= med_value;
            state       <= ST_GRAMS;
          end
        end
        ST_GRAMS: begin
          if (mul_done) begin
            if (!ema_seeded) begin
              ema_value  <= grams;
              ema_seeded <= 1'b1;
              state      <= ST_DONE;
            end else begin
              state <= ST_EMA;
            end
          end
        end
        ST_EMA: begin
          if (mul_done) begin
            ema_value <= sat48(64'(e_sum));
            state     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result register and request flag
  always_ff @(posedge clk) begin
    if (accept) begin
      item_ok <= sample.read_ok;
    end
    if (res_load) begin
      result.median_count    <= held_median;
      result.filtered_weight <= ema_value;
      result.sensor_ok       <= item_ok;
      result.samples_held    <= HELD_W'(fill);
    end
  end

endmodule

// ===== src/lcmf_median.sv =====
module lcmf_median
  import lcmf_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] median,
  output logic [$clog2(WINDOW_LEN+1)-1:0] fill
);

  localparam int IW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CW = $clog2(WINDOW_LEN + 1);

  logic signed [SAMPLE_W-1:0] ring [WINDOW_LEN];
  logic [IW-1:0] slot;
  logic [IW-1:0] cand_idx;
  logic          busy;

  logic signed [SAMPLE_W-1:0] cand;
  logic [CW-1:0] less_cnt;
  logic [CW-1:0] eq_cnt;
  logic [CW-1:0] mid_rank;
  logic          hit;

  // Rank of the current candidate among the filled entries
  always_comb begin
    cand     = ring[cand_idx];
    less_cnt = '0;
    eq_cnt   = '0;
    for (int j = 0; j < WINDOW_LEN; j++) begin
      if (CW'(j) < fill) begin
        if (ring[j] < cand)  less_cnt = less_cnt + CW'(1);
        if (ring[j] == cand) eq_cnt   = eq_cnt + CW'(1);
      end
    end
    mid_rank = fill >> 1;
    hit = (less_cnt <= mid_rank) &&
          ({1'b0, mid_rank} < ({1'b0, less_cnt} + {1'b0, eq_cnt}));
  end

  // Ring entries hold no reset; only filled ones are compared
  always_ff @(posedge clk) begin
    if (start) begin
      ring[slot] <= sample;
    end
  end

  // Fill, write slot and candidate walk
  always_ff @(posedge clk) begin
    if (rst) begin
      slot     <= '0;
      fill     <= '0;
      busy     <= 1'b0;
      done     <= 1'b0;
      cand_idx <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        slot     <= (slot == IW'(WINDOW_LEN - 1)) ? '0 : slot + IW'(1);
        if (fill != CW'(WINDOW_LEN)) fill <= fill + CW'(1);
        busy     <= 1'b1;
        cand_idx <= '0;
      end else if (busy) begin
        if (hit) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cand_idx <= cand_idx + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && hit) begin
      median <= cand;
    end
  end

endmodule

// ===== src/lcmf_booth_mul.sv =====
module lcmf_booth_mul #(
  parameter int AW = 49,
  parameter int BW = 25
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic                    done,
  output logic signed [AW+BW-1:0] product
);

  localparam int NW = $clog2(BW + 1);

  logic signed [AW-1:0] mcand;
  logic signed [AW:0]   hi;
  logic [BW-1:0]        lo;
  logic                 q;
  logic [NW-1:0]        cnt;
  logic                 busy;
  logic signed [AW:0]   sum;

  // Radix-2 Booth recoding of one multiplier bit per cycle
  always_comb begin
    unique case ({lo[0], q})
      2'b10:   sum = hi - {mcand[AW-1], mcand};
      2'b01:   sum = hi + {mcand[AW-1], mcand};
      default: sum = hi;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + NW'(1);
        if (cnt == NW'(BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Accumulate and shift right arithmetically
  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      hi    <= '0;
      lo    <= b;
      q     <= 1'b0;
    end else if (busy) begin
      hi <= {sum[AW], sum[AW:1]};
      lo <= {sum[0], lo[BW-1:1]};
      q  <= lo[0];
    end
  end

  assign product = {hi[AW-1:0], lo};

endmodule

// ===== src/lcmf_checker.sv =====
module lcmf_checker
  import lcmf_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        sample_valid,
  input logic        sample_ready,
  input logic        result_valid,
  input logic        result_ready,
  input lcmf_out_t   result
);

  logic [HELD_W-1:0] last_held;

  // Fill count of the last delivered result
  always_ff @(posedge clk) begin
    if (rst) begin
      last_held <= '0;
    end else if (result_valid && result_ready) begin
      last_held <= result.samples_held;
    end
  end

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // Nothing is shown straight after reset
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // One request at a time
  a_single: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("second request taken while busy");

  // The fill count never falls between delivered results
  a_fill: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && (WINDOW_LEN < 8) |-> result.samples_held >= last_held)
    else $error("fill count fell");

endmodule

bind load_cell_median_ema_filter_top lcmf_checker #(.WINDOW_LEN(WINDOW_LEN)) u_lcmf_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// ===== dv/tb_load_cell_median_ema_filter_top.sv =====
module tb_load_cell_median_ema_filter_top;
  import lcmf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = 5;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [2:0] ADDR_TARE = 3'(4 * REG_TARE);
  localparam logic [2:0] ADDR_GAIN = 3'(4 * REG_GAIN);

  // Scoreboard: carries its own copy of the filter state and configuration
  class weight_scoreboard;
    logic signed [23:0] ring[WIN];
    int unsigned        fill;
    int unsigned        slot;
    logic signed [23:0] median;
    longint             ema;
    bit                 seeded;
    logic signed [23:0] tare;
    logic signed [31:0] gain;
    lcmf_out_t          pending[$];

    function void clear();
      fill = 0; slot = 0; median = 0; ema = 0; seeded = 0;
      tare = 0; gain = 32'sd16777216;
      pending.delete();
    endfunction

    function longint clamp48(longint v);
      longint hi;
      hi = 64'sh0000_7FFF_FFFF_FFFF;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function logic signed [23:0] window_median();
      logic signed [23:0] t[WIN];
      logic signed [23:0] v;
      int j;
      for (int i = 0; i < WIN; i++) t[i] = ring[i];
      for (int i = 1; i < fill; i++) begin
        v = t[i];
        j = i;
        while (j > 0 && t[j-1] > v) begin
          t[j] = t[j-1];
          j--;
        end
        t[j] = v;
      end
      return t[fill / 2];
    endfunction

    // Note an accepted request and queue the result it should give
    function void note_request(lcmf_in_t req);
      lcmf_out_t r;
      longint grams, diff;
      if (req.read_ok) begin
        ring[slot] = req.raw_sample;
        if (fill < WIN) fill++;
        slot = (slot + 1) % WIN;
        median = window_median();
        if (gain < 17 && gain > -17) grams = 0;
        else grams = clamp48(((longint'(median) - longint'(tare)) * longint'(gain) + 128) >>> 8);
        if (!seeded) begin
          ema = grams;
          seeded = 1;
        end else begin
          diff = (grams - ema) * 11796;
          ema = clamp48(ema + ((diff + 32768) >>> 16));
        end
      end
      r.median_count = median;
      r.filtered_weight = ema[47:0];
      r.sensor_ok = req.read_ok;
      r.samples_held = fill[2:0];
      pending.push_back(r);
    endfunction

    task check_result(lcmf_out_t got);
      lcmf_out_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (got.median_count !== e.median_count)
        report_mismatch("median_count", got.median_count, e.median_count);
      if (got.filtered_weight !== e.filtered_weight)
        report_mismatch("filtered_weight", got.filtered_weight, e.filtered_weight);
      if (got.sensor_ok !== e.sensor_ok)
        report_mismatch("sensor_ok", got.sensor_ok, e.sensor_ok);
      if (got.samples_held !== e.samples_held)
        report_mismatch("samples_held", got.samples_held, e.samples_held);
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        sample_valid = 0;
  logic        sample_ready;
  lcmf_in_t    sample = '0;
  logic        result_valid;
  logic        result_ready = 0;
  lcmf_out_t   result;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  weight_scoreboard sb;
  int  cycles;
  int  stall_left = 0;
  bit  hold_off;
  int  errors;

  load_cell_median_ema_filter_top dut (.*);

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    if (errors <= 40) $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  initial forever #5 clk = ~clk;

  // Cycle count and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: note accepted results, random stalls, mostly short, a few long
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
    if (hold_off) begin
      result_ready <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_ready <= 0;
    end else if ($urandom_range(0, 99) < 10) begin
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
      result_ready <= 0;
    end else begin
      result_ready <= 1;
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_request(logic signed [23:0] raw, logic ok, bit gaps);
    lcmf_in_t req;
    req.raw_sample = raw;
    req.read_ok = ok;
    sample_valid <= 1;
    sample <= req;
    do @(posedge clk); while (!sample_ready);
    sb.note_request(req);
    if (gaps && $urandom_range(0, 3) == 0) begin
      sample_valid <= 0;
      idle_gap();
    end
  endtask

  task automatic wait_drained();
    sample_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == ADDR_TARE) sb.tare = data[23:0];
    else sb.gain = data;
    @(posedge clk);
  endtask

  function automatic logic signed [23:0] rand_raw();
    unique case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'($signed($urandom_range(0, 2000)) - 1000);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++)
      send_request(rand_raw(), $urandom_range(0, 9) != 0, 1);
  endtask

  initial begin
    logic [31:0] gains[8];
    logic [31:0] tares[5];
    sb = new();
    sb.clear();
    errors = 0;
    cycles = 0;
    hold_off = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: a failed read when empty, a later failed read, extremes, fill beyond the window
    send_request(24'sd100, 0, 0);
    send_request(24'sh7FFFFF, 1, 0);
    send_request(24'sh800000, 1, 0);
    send_request(24'sd0, 0, 0);
    send_request(24'sd5, 1, 0);
    send_request(-24'sd7, 1, 0);
    send_request(24'sd3, 1, 0);
    send_request(24'sh7FFFFF, 1, 0);
    send_request(24'sh800000, 1, 0);
    send_request(24'sd1, 1, 0);
    send_request(24'sh555555, 1, 0);
    send_request(24'shAAAAAA, 0, 0);
    wait_drained();

    // Receiver holds off while the sender keeps offering
    hold_off = 1;
    fork
      begin repeat (300) @(posedge clk); hold_off = 0; end
      random_phase(20);
    join
    wait_drained();

    // Configuration settings, extremes included; tiny-gain edges too
    gains = '{32'h7FFFFFFF, 32'h80000000, 32'd16, 32'hFFFFFFF0, 32'd17,
              32'hFFFFFFEF, 32'd0, 32'h0100_0000};
    tares = '{32'h7FFFFF, 32'h800000, 32'd0, 32'hFFFFFF, 32'h123456};
    for (int p = 0; p < 8; p++) begin
      write_reg(ADDR_GAIN, (p < 6) ? gains[p] : $urandom);
      write_reg(ADDR_TARE, (p < 5) ? tares[p] : {8'h0, 24'($urandom)});
      if (p == 2) send_request(24'sd9, 1, 0);
      random_phase(p == 7 ? 530 : 110);
      wait_drained();
    end
    write_reg(ADDR_GAIN, gains[6]);
    random_phase(40);
    wait_drained();
    write_reg(ADDR_GAIN, gains[7]);
    write_reg(ADDR_TARE, 32'd0);
    random_phase(80);
    wait_drained();

    if (errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== load_cell_median_ema_filter_top.f =====
src/lcmf_pkg.sv
src/lcmf_median.sv
src/lcmf_booth_mul.sv
src/load_cell_median_ema_filter_top.sv
src/lcmf_checker.sv
dv/tb_load_cell_median_ema_filter_top.sv
